FILE: rtl/core/positional_insert_delete_list_macros.svh
// Assertion macros used by the checker of the positional insert/delete list.
`ifndef POSITIONAL_INSERT_DELETE_LIST_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_LIST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIDL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIDL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pidl_pkg.sv
// Package with the types and constants of the positional insert/delete list.
`default_nettype none

package pidl_pkg;

    localparam int unsigned DEPTH_DEF = 64;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned POS_W     = 7;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned ST_W      = 2;
    localparam int unsigned CNT_W     = 7;
    localparam int unsigned IDX_W     = 6;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_OUT_RD,
        S_OUT_SEND,
        S_RESP
    } t_state;

    typedef struct packed {
        t_status            status;
        logic [CNT_W-1:0]   count;
        logic [IDX_W-1:0]   index;
        logic [DATA_W-1:0]  element;
        logic               last;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/pidl_in_if.sv
// Input channel interface carrying one command beat.
`default_nettype none

interface pidl_in_if;
    import pidl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, input ready, output opcode, output position, output value);
    modport sink   (input valid, output ready, input opcode, input position, input value);
endinterface

`default_nettype wire

FILE: rtl/core/pidl_out_if.sv
// Output channel interface carrying one result beat.
`default_nettype none

interface pidl_out_if;
    import pidl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [ST_W-1:0]          status;
    logic [CNT_W-1:0]         count;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] element;
    logic                     last;

    modport source (output valid, input ready, output status, output count,
                    output index, output element, output last);
    modport sink   (input valid, output ready, input status, input count,
                    input index, input element, input last);
endinterface

`default_nettype wire

FILE: rtl/core/positional_insert_delete_list.sv
// Top level of the positional insert/delete list with its entry memory and sequencer.
//
//   Channel   Direction   Beat contents
//   i_in      in          opcode, position, value
//   o_out     out         status, count, index, element, last
//
// Insert moves each entry at or above position up one place, reading and then writing it,
// and then writes the value; delete moves each entry above position down one place.
// A read-out reads and sends every entry in order; any other command goes to its result.
// The entry memory has one write port and one read port with a registered read.
// Reset clears the sequencer, the count and the output valid; the memory is not cleared.
// A stalled output holds the sequencer; a new command is taken while the last result waits.
`default_nettype none

module positional_insert_delete_list #(
    parameter int unsigned DEPTH = pidl_pkg::DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pidl_in_if.sink    i_in,
    pidl_out_if.source o_out
);
    import pidl_pkg::*;

    localparam int unsigned      AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [DATA_W-1:0]   r_val, n_val;
    t_status             r_status, n_status;
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;

    logic [DATA_W-1:0]   r_mem [DEPTH];
    logic [DATA_W-1:0]   r_rdata;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [AW-1:0]       mem_raddr;
    logic [DATA_W-1:0]   mem_wdata;

    logic [CNT_W-1:0]    idx_inc;
    logic [CNT_W-1:0]    idx_dec;
    logic                out_free;
    t_state              dec_next;
    t_status             dec_status;
    logic [CNT_W-1:0]    dec_idx;

    assign idx_inc  = r_idx + CNT_W'(1);
    assign idx_dec  = r_idx - CNT_W'(1);
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.status  = r_out.status;
    assign o_out.count   = r_out.count;
    assign o_out.index   = r_out.index;
    assign o_out.element = r_out.element;
    assign o_out.last    = r_out.last;

    always_comb begin
        dec_next   = S_RESP;
        dec_status = ST_OK;
        dec_idx    = '0;
        case (t_opcode'(i_in.opcode))
            OP_INSERT: begin
                dec_idx = r_count;
                if (i_in.position > r_count) begin
                    dec_status = ST_BADPOS;
                end else if (r_count >= DEPTH_CNT) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_next = S_INS_RD;
                end
            end
            OP_DELETE: begin
                dec_idx = i_in.position;
                if (r_count == '0) begin
                    dec_status = ST_EMPTY;
                end else if (i_in.position >= r_count) begin
                    dec_status = ST_BADPOS;
                end else begin
                    dec_next = S_DEL_RD;
                end
            end
            OP_READ: begin
                if (r_count == '0) begin
                    dec_status = ST_EMPTY;
                end else begin
                    dec_next = S_OUT_RD;
                end
            end
            default: begin
                dec_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = dec_next;
                end
            end
            S_INS_RD: begin
                n_state = (r_idx == r_pos) ? S_RESP : S_INS_WR;
            end
            S_INS_WR: begin
                n_state = S_INS_RD;
            end
            S_DEL_RD: begin
                n_state = (idx_inc < r_count) ? S_DEL_WR : S_RESP;
            end
            S_DEL_WR: begin
                n_state = S_DEL_RD;
            end
            S_OUT_RD: begin
                n_state = S_OUT_SEND;
            end
            S_OUT_SEND: begin
                if (out_free) begin
                    n_state = (idx_inc == r_count) ? S_IDLE : S_OUT_RD;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_val       = r_val;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_idx[AW-1:0];
        mem_wdata   = r_rdata;
        mem_raddr   = r_idx[AW-1:0];

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_pos    = i_in.position;
                    n_val    = i_in.value;
                    n_idx    = dec_idx;
                    n_status = dec_status;
                end
            end
            S_INS_RD: begin
                if (r_idx == r_pos) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos[AW-1:0];
                    mem_wdata = r_val;
                    n_count   = r_count + CNT_W'(1);
                end else begin
                    mem_raddr = idx_dec[AW-1:0];
                end
            end
            S_INS_WR: begin
                mem_we = 1'b1;
                n_idx  = idx_dec;
            end
            S_DEL_RD: begin
                if (idx_inc < r_count) begin
                    mem_raddr = idx_inc[AW-1:0];
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_DEL_WR: begin
                mem_we = 1'b1;
                n_idx  = idx_inc;
            end
            S_OUT_RD: begin
                mem_raddr = r_idx[AW-1:0];
            end
            S_OUT_SEND: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out.status  = ST_OK;
                    n_out.count   = r_count;
                    n_out.index   = r_idx[IDX_W-1:0];
                    n_out.element = r_rdata;
                    n_out.last    = (idx_inc == r_count);
                    n_idx         = idx_inc;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out.status  = r_status;
                    n_out.count   = r_count;
                    n_out.index   = '0;
                    n_out.element = '0;
                    n_out.last    = 1'b1;
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_status <= n_status;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/pidl_checker.sv
// Port-level checker for the positional insert/delete list and its bind statement.
`default_nettype none

`include "positional_insert_delete_list_macros.svh"

module pidl_checker #(
    parameter int unsigned DEPTH = pidl_pkg::DEPTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [pidl_pkg::ST_W-1:0]     i_out_status,
    input logic [pidl_pkg::CNT_W-1:0]    i_out_count,
    input logic [pidl_pkg::IDX_W-1:0]    i_out_index,
    input logic                          i_out_last
);
    import pidl_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    `PIDL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_status) && $stable(i_out_count) && $stable(i_out_index) && $stable(i_out_last), "Stalled result beat changed.")
    `PIDL_ASSERT_NOW(a_err_single, i_clk, i_rst_n, i_out_valid && (i_out_status != ST_OK), i_out_last && (i_out_index == '0), "Error result is not a lone final beat.")
    `PIDL_ASSERT_NOW(a_full_count, i_clk, i_rst_n, i_out_valid && (i_out_status == ST_FULL), i_out_count == DEPTH_CNT, "Full status with a count below the depth.")
    `PIDL_ASSERT_NOW(a_busy_readout, i_clk, i_rst_n, i_out_valid && !i_out_last, !i_in_ready, "Command taken in the middle of a read-out.")

endmodule

bind positional_insert_delete_list pidl_checker #(.DEPTH(DEPTH)) u_pidl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_count  (o_out.count),
    .i_out_index  (o_out.index),
    .i_out_last   (o_out.last)
);

`default_nettype wire

FILE: dv/positional_insert_delete_list_tb.sv
// Self-checking testbench that drives list commands and compares every result beat.
module positional_insert_delete_list_tb;
    import pidl_pkg::*;

    localparam int unsigned LIST_DEPTH  = DEPTH_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned TAIL_CYCLES = 300;
    localparam int unsigned PHASE_ITEMS = 125;

    class list_tracker;
        int unsigned       depth;
        logic [DATA_W-1:0] slots [DEPTH_DEF];
        int unsigned       held;
        t_result           awaited_results[$];
        int unsigned       mismatches;
        int unsigned       commands_noted;
        int unsigned       beats_checked;
        int unsigned       full_hits;
        int unsigned       empty_hits;
        int unsigned       badpos_hits;

        function new(int unsigned list_depth);
            depth          = list_depth;
            held           = 0;
            mismatches     = 0;
            commands_noted = 0;
            beats_checked  = 0;
            full_hits      = 0;
            empty_hits     = 0;
            badpos_hits    = 0;
        endfunction

        function void note_command(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                   logic [DATA_W-1:0] val);
            t_result beat;
            t_status outcome;
            int      i;
            commands_noted++;
            beat    = '0;
            outcome = ST_OK;
            case (op)
                OP_INSERT: begin
                    if (pos > held) begin
                        outcome = ST_BADPOS;
                    end else if (held >= depth) begin
                        outcome = ST_FULL;
                    end else begin
                        for (i = held; i > pos; i--) slots[i] = slots[i-1];
                        slots[pos] = val;
                        held++;
                    end
                end
                OP_DELETE: begin
                    if (held == 0) begin
                        outcome = ST_EMPTY;
                    end else if (pos >= held) begin
                        outcome = ST_BADPOS;
                    end else begin
                        for (i = pos; i + 1 < held; i++) slots[i] = slots[i+1];
                        held--;
                    end
                end
                OP_READ: begin
                    if (held == 0) begin
                        outcome = ST_EMPTY;
                    end else begin
                        for (i = 0; i < held; i++) begin
                            beat.status  = ST_OK;
                            beat.count   = CNT_W'(held);
                            beat.index   = IDX_W'(i);
                            beat.element = slots[i];
                            beat.last    = (i == held - 1);
                            awaited_results.push_back(beat);
                        end
                        return;
                    end
                end
                default: ;
            endcase
            case (outcome)
                ST_FULL:   full_hits++;
                ST_EMPTY:  empty_hits++;
                ST_BADPOS: badpos_hits++;
                default:   ;
            endcase
            beat.status = outcome;
            beat.count  = CNT_W'(held);
            beat.last   = 1'b1;
            awaited_results.push_back(beat);
        endfunction

        function void check_beat(t_result got);
            t_result want;
            if (awaited_results.size() == 0) begin
                $error("unexpected result beat: status %0d count %0d index %0d",
                       got.status, got.count, got.index);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            beats_checked++;
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.count !== want.count) begin
                $error("count: expected %0d, got %0d", want.count, got.count);
                mismatches++;
            end
            if (got.index !== want.index) begin
                $error("index: expected %0d, got %0d", want.index, got.index);
                mismatches++;
            end
            if (got.element !== want.element) begin
                $error("element: expected %0d, got %0d",
                       $signed(want.element), $signed(got.element));
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned cycle_count;
    t_result     seen_beat;
    list_tracker tracker;

    pidl_in_if  cmd_if ();
    pidl_out_if res_if ();

    positional_insert_delete_list #(.DEPTH(LIST_DEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && res_if.valid && res_if.ready) begin
            seen_beat.status  = t_status'(res_if.status);
            seen_beat.count   = res_if.count;
            seen_beat.index   = res_if.index;
            seen_beat.element = res_if.element;
            seen_beat.last    = res_if.last;
            tracker.check_beat(seen_beat);
        end
    end

    task automatic send_command(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid    <= 1'b0;
            cmd_if.opcode   <= OP_W'($urandom_range(3));
            cmd_if.position <= POS_W'($urandom_range(127));
            cmd_if.value    <= $urandom();
            @(posedge i_clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.opcode   <= op;
        cmd_if.position <= pos;
        cmd_if.value    <= val;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        tracker.note_command(op, pos, val);
    endtask

    task automatic wait_for_results();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.awaited_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_command(input bit growing);
        int unsigned       roll;
        int unsigned       ins_pct;
        int unsigned       del_pct;
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        roll    = $urandom_range(99);
        ins_pct = growing ? 75 : 12;
        del_pct = growing ? 10 : 73;
        pos     = POS_W'($urandom_range(127));
        if (roll < ins_pct) begin
            op  = OP_INSERT;
            pos = POS_W'($urandom_range(tracker.held));
        end else if (roll < ins_pct + del_pct) begin
            op  = OP_DELETE;
            pos = POS_W'((tracker.held == 0) ? 0 : $urandom_range(tracker.held - 1));
        end else if (roll < 92) begin
            op = OP_READ;
        end else if (roll < 95) begin
            op = OP_UNUSED;
        end else if (roll[0]) begin
            op  = OP_INSERT;
            pos = POS_W'($urandom_range(127, tracker.held + 1));
        end else begin
            op  = OP_DELETE;
            pos = POS_W'($urandom_range(127, tracker.held));
        end
        send_command(op, pos, $urandom());
    endtask

    initial begin
        tracker         = new(LIST_DEPTH);
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        cmd_if.valid    = 1'b0;
        cmd_if.opcode   = OP_INSERT;
        cmd_if.position = '0;
        cmd_if.value    = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_command(OP_READ,   7'd0,   32'd0);
        send_command(OP_DELETE, 7'd0,   32'd0);
        send_command(OP_DELETE, 7'd127, 32'hFFFF_FFFF);
        send_command(OP_INSERT, 7'd1,   32'd5);
        send_command(OP_INSERT, 7'd127, 32'd6);
        send_command(OP_INSERT, 7'd0,   32'h8000_0000);
        send_command(OP_INSERT, 7'd1,   32'h7FFF_FFFF);
        send_command(OP_INSERT, 7'd0,   32'hFFFF_FFFF);
        send_command(OP_INSERT, 7'd1,   32'd0);
        send_command(OP_UNUSED, 7'd127, 32'hFFFF_FFFF);
        send_command(OP_READ,   7'd127, 32'hFFFF_FFFF);
        send_command(OP_DELETE, 7'd4,   32'd0);
        send_command(OP_DELETE, 7'd1,   32'd0);
        send_command(OP_DELETE, 7'd2,   32'd0);
        send_command(OP_DELETE, 7'd0,   32'd0);
        send_command(OP_READ,   7'd0,   32'd0);
        send_command(OP_INSERT, 7'd1,   32'h5555_AAAA);
        send_command(OP_READ,   7'd64,  32'd0);
        wait_for_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) random_command(phase % 2 == 0);
            wait_for_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Ran %0d commands and checked %0d result beats.",
                 tracker.commands_noted, tracker.beats_checked);
        $display("Error statuses seen: %0d full, %0d empty, %0d bad position.",
                 tracker.full_hits, tracker.empty_hits, tracker.badpos_hits);
        if (tracker.mismatches == 0 && tracker.awaited_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
